### src/pressure_temperature_compensation_macros.svh
// assertion macros for the pressure and temperature compensation block
`ifndef PRESSURE_TEMPERATURE_COMPENSATION_MACROS_SVH
`define PRESSURE_TEMPERATURE_COMPENSATION_MACROS_SVH

// same-cycle implication, checked outside reset
`define PTC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define PTC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### src/ptc_pkg.sv
// shared types, constants and helpers of the compensation block
package ptc_pkg;

   localparam int DivStages = 32;

   localparam logic [1:0] CSR_TRIM_TEMPERATURE   = 2'd0;
   localparam logic [1:0] CSR_TRIM_PRESSURE_LOW  = 2'd1;
   localparam logic [1:0] CSR_TRIM_PRESSURE_HIGH = 2'd2;
   localparam logic [1:0] CSR_TRIM_PRESSURE_NINE = 2'd3;

   localparam logic [31:0] ROUND_TEMP   = 32'd128;
   localparam logic [31:0] FINE_OFFSET  = 32'd64000;
   localparam logic [31:0] DEN_OFFSET   = 32'd32768;
   localparam logic [31:0] ADC_FULL     = 32'd1048576;
   localparam logic [31:0] PRESS_SCALE  = 32'd3125;
   localparam logic [32:0] SEA_LEVEL_PA = 33'd101325;
   localparam logic [36:0] ALT_FACTOR   = 37'd9;

   typedef struct packed {
      logic [19:0] raw_temperature;
      logic [19:0] raw_pressure;
   } req_type;

   typedef struct packed {
      logic signed [31:0] temperature_centi;
      logic [31:0]        pressure_pa;
      logic               divisor_zero;
      logic signed [31:0] altitude_cm;
   } rsp_type;

   // one divider stage: partial remainder, dividend bits left, quotient so far
   typedef struct packed {
      logic [31:0] rem;
      logic [31:0] dvd;
      logic [31:0] quo;
      logic [31:0] den;
      logic [31:0] temp;
      logic        zero;
      logic        dbl;
   } div_stage_type;

   // arithmetic right shift of a 32-bit pattern
   function automatic logic [31:0] asr(input logic [31:0] x, input int n);
      logic signed [31:0] s;
      s = $signed(x) >>> n;
      return $unsigned(s);
   endfunction

   // sign-extend a 16-bit trim word
   function automatic logic [31:0] sx16(input logic [15:0] x);
      return {{16{x[15]}}, x};
   endfunction

endpackage

### src/pressure_temperature_compensation.sv
// Top level of the pressure and temperature compensation pipeline
//
// Each request carries one raw 20-bit temperature and one raw 20-bit pressure.
// The result gives temperature in 0.01 degC, pressure in Pa, a flag for a zero
// pressure divisor and an altitude estimate in centimetres.
// Trim words are written through the csr port (index, data, write enable).
// Write them only while no request is in flight; the block does not check.
// The pipeline has 8 stages of 32-bit multiply/add for the temperature and
// divisor terms, a 32-stage restoring divider that resolves one quotient bit a
// stage, then 4 stages for the pressure correction and altitude. Throughput is
// one request per cycle when not stalled; the divider pipeline sets the depth.
// When rsp_stall is high while a result is held, the whole pipeline freezes
// and req_stall goes high; nothing is lost or repeated.
// Synchronous reset clears all trim registers to zero and empties the
// pipeline; with zero trims the divisor is zero and results carry the flag.
`include "pressure_temperature_compensation_macros.svh"

module pressure_temperature_compensation (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ptc_pkg::req_type  req,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ptc_pkg::rsp_type  rsp,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [63:0]       csr_wdata
);
   import ptc_pkg::*;

   // trim registers
   logic [47:0] trim_t_ff;
   logic [63:0] trim_pl_ff, trim_ph_ff;
   logic [15:0] trim_p9_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         trim_t_ff  <= '0;
         trim_pl_ff <= '0;
         trim_ph_ff <= '0;
         trim_p9_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TRIM_TEMPERATURE:   trim_t_ff  <= csr_wdata[47:0];
            CSR_TRIM_PRESSURE_LOW:  trim_pl_ff <= csr_wdata;
            CSR_TRIM_PRESSURE_HIGH: trim_ph_ff <= csr_wdata;
            CSR_TRIM_PRESSURE_NINE: trim_p9_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
   assign t1 = {16'd0, trim_t_ff[15:0]};
   assign t2 = sx16(trim_t_ff[31:16]);
   assign t3 = sx16(trim_t_ff[47:32]);
   assign p1 = {16'd0, trim_pl_ff[15:0]};
   assign p2 = sx16(trim_pl_ff[31:16]);
   assign p3 = sx16(trim_pl_ff[47:32]);
   assign p4 = sx16(trim_pl_ff[63:48]);
   assign p5 = sx16(trim_ph_ff[15:0]);
   assign p6 = sx16(trim_ph_ff[31:16]);
   assign p7 = sx16(trim_ph_ff[47:32]);
   assign p8 = sx16(trim_ph_ff[63:48]);
   assign p9 = sx16(trim_p9_ff);

   // global advance: the pipeline moves unless a held result is stalled
   logic adv;
   assign adv       = !rsp_valid || !rsp_stall;
   assign req_stall = !adv;

   // valid bits
   logic [7:0] fv_ff;
   logic [DivStages-1:0] dv_ff;
   logic [3:0] pv_ff;

   // front stage registers
   logic [31:0] m1_ff, m2_ff, at_ff, m3_ff, fine_ff, pa_ff;
   logic [31:0] temp4_ff, sq_ff, m5_ff, m6_ff;
   logic [31:0] temp5_ff, b5_ff, m7_ff, m5b_ff, m6b_ff;
   logic [31:0] temp6_ff, b6_ff, a6_ff;
   logic [31:0] temp7_ff, m8_ff, np_ff;
   logic [31:0] temp8_ff, den_ff, pm_ff;
   logic [19:0] ap1_ff, ap2_ff, ap3_ff, ap4_ff, ap5_ff, ap6_ff;

   // front stage logic
   logic [31:0] x1_in, d_in, m1_in, m2_in, fine_in, qa_in, b6_in;
   assign x1_in   = {15'd0, req.raw_temperature[19:3]} - (t1 << 1);
   assign d_in    = {16'd0, req.raw_temperature[19:4]} - t1;
   assign m1_in   = x1_in * t2;
   assign m2_in   = d_in * d_in;
   assign fine_in = at_ff + asr(m3_ff, 14);
   assign qa_in   = asr(pa_ff, 2);
   assign b6_in   = b5_ff + (m5b_ff << 1);

   // divider stages
   div_stage_type div_ff [DivStages];
   div_stage_type div_in [DivStages];

   always_comb begin
      div_stage_type prev;
      logic [32:0] trial;
      for (int k = 0; k < DivStages; k++) begin
         if (k == 0) begin
            prev.rem  = '0;
            prev.dvd  = pm_ff[31] ? pm_ff : (pm_ff << 1);
            prev.quo  = '0;
            prev.den  = den_ff;
            prev.temp = temp8_ff;
            prev.zero = (den_ff == 32'd0);
            prev.dbl  = pm_ff[31];
         end else begin
            prev = div_ff[k-1];
         end
         trial = {prev.rem, prev.dvd[31]};
         div_in[k] = prev;
         div_in[k].dvd = prev.dvd << 1;
         if (trial >= {1'b0, prev.den}) begin
            div_in[k].rem = 32'(trial - {1'b0, prev.den});
            div_in[k].quo = {prev.quo[30:0], 1'b1};
         end else begin
            div_in[k].rem = trial[31:0];
            div_in[k].quo = {prev.quo[30:0], 1'b0};
         end
      end
   end

   // pressure correction stages
   div_stage_type last;
   logic [31:0] p0_in, pq_ff, m9_ff, m10_ff, pq2_ff, m11_ff, bq_ff, pf_ff;
   logic [31:0] temp_p1_ff, temp_p2_ff, temp_p3_ff, pf_in;
   logic        z_p1_ff, z_p2_ff, z_p3_ff;
   logic signed [32:0] diff_in;
   logic signed [36:0] alt_in;
   logic [31:0] alt_sat;
   rsp_type rsp_ff;

   assign last    = div_ff[DivStages-1];
   assign p0_in   = last.dbl ? (last.quo << 1) : last.quo;
   assign pf_in   = z_p2_ff ? 32'd0
                  : pq2_ff + asr(asr(m11_ff, 12) + bq_ff + p7, 4);
   assign diff_in = $signed(SEA_LEVEL_PA) - $signed({1'b0, pf_ff});
   assign alt_in  = 37'(diff_in) * $signed(ALT_FACTOR);

   // saturate the altitude to the signed 32-bit range
   always_comb begin
      if (alt_in > 37'sd2147483647)
         alt_sat = 32'h7fffffff;
      else if (alt_in < -37'sd2147483648)
         alt_sat = 32'h80000000;
      else
         alt_sat = alt_in[31:0];
   end

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         fv_ff <= '0;
         dv_ff <= '0;
         pv_ff <= '0;
      end else if (adv) begin
         fv_ff <= {fv_ff[6:0], req_valid};
         dv_ff <= {dv_ff[DivStages-2:0], fv_ff[7]};
         pv_ff <= {pv_ff[2:0], dv_ff[DivStages-1]};
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (adv) begin
         m1_ff    <= m1_in;
         m2_ff    <= m2_in;
         ap1_ff   <= req.raw_pressure;
         at_ff    <= asr(m1_ff, 11);
         m3_ff    <= asr(m2_ff, 12) * t3;
         ap2_ff   <= ap1_ff;
         fine_ff  <= fine_in;
         pa_ff    <= asr(fine_in, 1) - FINE_OFFSET;
         ap3_ff   <= ap2_ff;
         temp4_ff <= asr((fine_ff << 2) + fine_ff + ROUND_TEMP, 8);
         sq_ff    <= qa_in * qa_in;
         m5_ff    <= pa_ff * p5;
         m6_ff    <= p2 * pa_ff;
         ap4_ff   <= ap3_ff;
         temp5_ff <= temp4_ff;
         b5_ff    <= asr(sq_ff, 11) * p6;
         m7_ff    <= p3 * asr(sq_ff, 13);
         m5b_ff   <= m5_ff;
         m6b_ff   <= m6_ff;
         ap5_ff   <= ap4_ff;
         temp6_ff <= temp5_ff;
         b6_ff    <= asr(b6_in, 2) + (p4 << 16);
         a6_ff    <= asr(asr(m7_ff, 3) + asr(m6b_ff, 1), 18);
         ap6_ff   <= ap5_ff;
         temp7_ff <= temp6_ff;
         m8_ff    <= (DEN_OFFSET + a6_ff) * p1;
         np_ff    <= (ADC_FULL - {12'd0, ap6_ff}) - asr(b6_ff, 12);
         temp8_ff <= temp7_ff;
         den_ff   <= asr(m8_ff, 15);
         pm_ff    <= np_ff * PRESS_SCALE;
         for (int k = 0; k < DivStages; k++) div_ff[k] <= div_in[k];
         pq_ff      <= p0_in;
         m9_ff      <= (p0_in >> 3) * (p0_in >> 3);
         m10_ff     <= (p0_in >> 2) * p8;
         temp_p1_ff <= last.temp;
         z_p1_ff    <= last.zero;
         pq2_ff     <= pq_ff;
         m11_ff     <= p9 * (m9_ff >> 13);
         bq_ff      <= asr(m10_ff, 13);
         temp_p2_ff <= temp_p1_ff;
         z_p2_ff    <= z_p1_ff;
         pf_ff      <= pf_in;
         temp_p3_ff <= temp_p2_ff;
         z_p3_ff    <= z_p2_ff;
         rsp_ff.temperature_centi <= $signed(temp_p3_ff);
         rsp_ff.pressure_pa       <= pf_ff;
         rsp_ff.divisor_zero      <= z_p3_ff;
         rsp_ff.altitude_cm       <= $signed(alt_sat);
      end
   end

   assign rsp_valid = pv_ff[3];
   assign rsp       = rsp_ff;

   // checks on the result
   `PTC_ASSERT_NOW(a_zero_press, clock, reset, rsp_valid && rsp.divisor_zero, rsp.pressure_pa == 32'd0, "zero divisor with nonzero pressure")
   `PTC_ASSERT_NOW(a_zero_alt, clock, reset, rsp_valid && rsp.divisor_zero, rsp.altitude_cm == 32'sd911925, "zero divisor altitude wrong")
   `PTC_ASSERT_NOW(a_alt_sign, clock, reset, rsp_valid && (rsp.pressure_pa <= 32'd101325), !rsp.altitude_cm[31], "altitude negative below sea-level pressure")
   `PTC_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(fv_ff), "pipeline moved while stalled")

endmodule
